/* rtl/wmlc_pkg.sv */
`default_nettype none

package wmlc_pkg;

  // Field widths of the channels
  localparam int SAMPLE_W   = 12;
  localparam int MEDIAN_W   = 12;
  localparam int CAL_W      = 15;
  localparam int GAIN_W     = 17;
  localparam int OFFSET_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Fraction bits of the gain
  localparam int GAIN_FRAC = 16;

  // Parameter defaults
  localparam int WINDOW_DEF      = 30;
  localparam int SAMPLE_BITS_DEF = 12;

  // Register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(55705);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(-496);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_SCAN,
    S_TALLY,
    S_MED,
    S_MUL,
    S_ADD
  } state_t;

endpackage

`default_nettype wire

/* rtl/wmlc_intf.sv */
`default_nettype none

// Input command channel
interface wmlc_item_if;
  import wmlc_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

// Result channel
interface wmlc_result_if;
  import wmlc_pkg::*;
  logic                valid;
  logic                ready;
  logic [MEDIAN_W-1:0] median_code;
  logic [CAL_W-1:0]    calibrated_value;

  modport source (output valid, output median_code, output calibrated_value, input ready);
  modport sink   (input valid, input median_code, input calibrated_value, output ready);
endinterface

// Register write channel
interface wmlc_cfg_if;
  import wmlc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/window_median_linear_calibrator.sv */
// Channel   Dir  Payload                              Transaction when
// item      in   command, sample                      item.valid & item.ready
// result    out  median_code, calibrated_value        result.valid & result.ready
// cfg       in   index (0 gain_q16, 1 offset), data   cfg.valid & cfg.ready
//
// Push: item.ready is high in idle, so pushes can stream every cycle while no evaluate runs.
// Evaluate: the rank count steps one ring entry per cycle through the single
//   read port of the ring.
// Reset (rst, synchronous): ring reads as zero via per-entry valid bits, no
//   clearing pass. A finished result waits in the output register; a second
//   evaluate holds in its last step until that register is free.
`default_nettype none

module window_median_linear_calibrator #(
  parameter int WINDOW = wmlc_pkg::WINDOW_DEF
) (
  input  wire           clk,
  input  wire           rst,
  wmlc_item_if.sink     item,
  wmlc_result_if.source result,
  wmlc_cfg_if.sink      cfg
);

  import wmlc_pkg::*;

  // Sample width is fixed by the channel
  localparam int SAMPLE_BITS = SAMPLE_W;
  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  // Sorted ranks of the two middle entries (equal for an odd window)
  localparam int K_LO   = (WINDOW - 1) / 2;
  localparam int K_HI   = WINDOW / 2;

  // Configuration registers
  logic [GAIN_W-1:0]   gain_q16;
  logic [OFFSET_W-1:0] offset;

  // Sample ring: memory plus valid bits so unwritten entries read as zero
  logic [SAMPLE_BITS-1:0] ring [WINDOW];
  logic [WINDOW-1:0]      ring_vld;
  logic [PTR_W-1:0]       write_pointer;
  logic [PTR_W-1:0]       rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_vld;
  logic [SAMPLE_BITS-1:0] sample_val;

  // Sequencer
  state_t                 state, state_next;
  logic [PTR_W-1:0]       cand_idx;
  logic [CNT_W-1:0]       scan_idx;
  logic [SAMPLE_BITS-1:0] cand;
  logic [CNT_W-1:0]       lt_cnt;
  logic [CNT_W-1:0]       le_cnt;
  logic [SAMPLE_BITS-1:0] mid_lo;
  logic [SAMPLE_BITS-1:0] mid_hi;
  logic [SAMPLE_BITS:0]   pair_sum;
  logic [SAMPLE_BITS-1:0] med;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W+CAL_W-1:0] prod_wide;
  logic [CAL_W-1:0]       scaled;
  logic [CAL_W-1:0]       offset_ext;
  logic                   push_go;
  logic                   eval_go;
  logic                   out_free;

  logic                   out_valid;
  logic [MEDIAN_W-1:0]    out_median;
  logic [CAL_W-1:0]       out_cal;

  assign cfg.ready = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign push_go = item.valid && item.ready && (item.command == CMD_PUSH);
  assign eval_go = item.valid && item.ready && (item.command == CMD_EVAL);
  assign out_free = !out_valid || result.ready;

  assign result.valid            = out_valid;
  assign result.median_code      = out_median;
  assign result.calibrated_value = out_cal;

  assign sample_val = rd_vld ? rd_data : '0;
  assign pair_sum   = {1'b0, mid_lo} + {1'b0, mid_hi};
  assign prod_wide  = {{CAL_W{1'b0}}, prod} >> GAIN_FRAC;
  assign scaled     = prod_wide[CAL_W-1:0];
  assign offset_ext = {{(CAL_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q16 <= GAIN_RESET;
      offset   <= OFFSET_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_GAIN:   gain_q16 <= GAIN_W'(cfg.data);
        REG_OFFSET: offset   <= OFFSET_W'(cfg.data);
        default:    ;
      endcase
    end
  end

  // Ring storage and registered read port
  always_ff @(posedge clk) begin
    if (push_go) begin
      ring[write_pointer] <= SAMPLE_BITS'(item.sample);
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld      <= '0;
      write_pointer <= '0;
      rd_vld        <= 1'b0;
    end else begin
      rd_vld <= ring_vld[rd_addr];
      if (push_go) begin
        ring_vld[write_pointer] <= 1'b1;
        if (write_pointer == PTR_W'(WINDOW - 1)) begin
          write_pointer <= '0;
        end else begin
          write_pointer <= write_pointer + 1'b1;
        end
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and read address
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    case (state)
      S_IDLE: begin
        if (eval_go) state_next = S_LOAD;
      end
      S_LOAD: begin
        rd_addr    = cand_idx;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx == CNT_W'(WINDOW)) begin
          state_next = S_TALLY;
        end else begin
          rd_addr = scan_idx[PTR_W-1:0];
        end
      end
      S_TALLY: begin
        state_next = (cand_idx == PTR_W'(WINDOW - 1)) ? S_MED : S_LOAD;
      end
      S_MED:   state_next = S_MUL;
      S_MUL:   state_next = S_ADD;
      S_ADD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Rank count: a candidate is the k-th smallest when lt <= k < le
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cand_idx <= '0;
      end
      S_FETCH: begin
        cand     <= sample_val;
        scan_idx <= CNT_W'(1);
        lt_cnt   <= '0;
        le_cnt   <= '0;
      end
      S_SCAN: begin
        lt_cnt <= lt_cnt + CNT_W'(sample_val < cand);
        le_cnt <= le_cnt + CNT_W'(sample_val <= cand);
        if (scan_idx != CNT_W'(WINDOW)) scan_idx <= scan_idx + 1'b1;
      end
      S_TALLY: begin
        if (lt_cnt <= CNT_W'(K_LO) && CNT_W'(K_LO) < le_cnt) mid_lo <= cand;
        if (lt_cnt <= CNT_W'(K_HI) && CNT_W'(K_HI) < le_cnt) mid_hi <= cand;
        cand_idx <= cand_idx + 1'b1;
      end
      S_MED: begin
        med <= pair_sum[SAMPLE_BITS:1];
      end
      S_MUL: begin
        prod <= PROD_W'(med) * PROD_W'(gain_q16);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_ADD && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ADD && out_free) begin
      out_median <= MEDIAN_W'(med);
      out_cal    <= scaled + offset_ext;
    end
  end

endmodule

`default_nettype wire
